// ----- src/bbc_pkg.sv -----
`default_nettype none

package bbc_pkg;

   localparam int ENTRY_COUNT_DEF = 16;
   localparam int BLOCK_BITS_DEF  = 16;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   // request opcodes
   localparam logic [1:0] OP_ACQUIRE = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NO_FREE = 2'd1;
   localparam logic [1:0] STAT_UNHELD  = 2'd2;

   // disk commands
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HIT_SCAN,
      S_FREE_SCAN,
      S_ACQ_UPD,
      S_WR_RD,
      S_WR_UPD,
      S_REL_RD,
      S_REL_CHK,
      S_REL_SWEEP,
      S_PUT
   } ctl_state_type;

endpackage

`default_nettype wire

// ----- src/block_buffer_cache_mru_top.sv -----
// flow: a write reads then updates its entry; an acquire scans for a hit and on a
// miss scans again for a free entry; a release to count zero sweeps every entry
// throughput: one word at a time, set by the entry scan through the entry
// memory (one entry read per cycle)
// reset: synchronous, active high; empties the response register and returns
// every entry to tag 0, count 0, invalid, clean, rank ENTRY_COUNT-1-index
`default_nettype none

module block_buffer_cache_mru_top
   import bbc_pkg::*;
#(
   parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
   parameter int BLOCK_BITS  = BLOCK_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [15:0] req_block_number,
   input  wire logic [3:0]  req_buffer_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [1:0]  rsp_status,
   output logic      [3:0]  rsp_entry_index,
   output logic      [1:0]  rsp_disk_command,
   output logic      [15:0] rsp_disk_block
);

   localparam int IB = $clog2(ENTRY_COUNT);

   logic [IB-1:0]         rd_addr, wr_addr, rd_rank, wr_rank;
   logic [BLOCK_BITS-1:0] rd_tag, wr_tag;
   logic [7:0]            rd_count, wr_count;
   logic                  rd_valid, rd_dirty, wr_en, wr_valid, wr_dirty;

   bbc_ctrl #(
      .ENTRY_COUNT (ENTRY_COUNT),
      .BLOCK_BITS  (BLOCK_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_block_number (req_block_number),
      .req_buffer_index (req_buffer_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_disk_command (rsp_disk_command),
      .rsp_disk_block   (rsp_disk_block),
      .rd_addr          (rd_addr),
      .rd_tag           (rd_tag),
      .rd_count         (rd_count),
      .rd_valid         (rd_valid),
      .rd_dirty         (rd_dirty),
      .rd_rank          (rd_rank),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_tag           (wr_tag),
      .wr_count         (wr_count),
      .wr_valid         (wr_valid),
      .wr_dirty         (wr_dirty),
      .wr_rank          (wr_rank)
   );

   bbc_store #(
      .ENTRY_COUNT (ENTRY_COUNT),
      .BLOCK_BITS  (BLOCK_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_tag   (rd_tag),
      .rd_count (rd_count),
      .rd_valid (rd_valid),
      .rd_dirty (rd_dirty),
      .rd_rank  (rd_rank),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_tag   (wr_tag),
      .wr_count (wr_count),
      .wr_valid (wr_valid),
      .wr_dirty (wr_dirty),
      .wr_rank  (wr_rank)
   );

endmodule

`default_nettype wire

// ----- src/bbc_store.sv -----
`default_nettype none

module bbc_store
   import bbc_pkg::*;
#(
   parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
   parameter int BLOCK_BITS  = BLOCK_BITS_DEF,
   localparam int IB = $clog2(ENTRY_COUNT)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [IB-1:0]         rd_addr,
   output logic      [BLOCK_BITS-1:0] rd_tag,
   output logic      [7:0]            rd_count,
   output logic                       rd_valid,
   output logic                       rd_dirty,
   output logic      [IB-1:0]         rd_rank,
   input  wire logic                  wr_en,
   input  wire logic [IB-1:0]         wr_addr,
   input  wire logic [BLOCK_BITS-1:0] wr_tag,
   input  wire logic [7:0]            wr_count,
   input  wire logic                  wr_valid,
   input  wire logic                  wr_dirty,
   input  wire logic [IB-1:0]         wr_rank
);

   localparam int WW = BLOCK_BITS + 8 + 2 + IB;
   localparam logic [IB-1:0] LAST_RANK = IB'(ENTRY_COUNT - 1);

   logic [WW-1:0]          entry_mem_ff [ENTRY_COUNT];
   logic [ENTRY_COUNT-1:0] init_ff;
   logic [WW-1:0]          rd_word_ff;
   logic [IB-1:0]          rd_addr_ff;
   logic                   rd_init_ff;
   logic [WW-1:0]          wr_word;

   assign wr_word = {wr_tag, wr_count, wr_valid, wr_dirty, wr_rank};

   // entries never written read as their reset contents
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= '0;
      end else if (wr_en) begin
         init_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_word;
      end
      rd_word_ff <= entry_mem_ff[rd_addr];
      rd_addr_ff <= rd_addr;
      rd_init_ff <= init_ff[rd_addr];
   end

   always_comb begin
      if (rd_init_ff) begin
         {rd_tag, rd_count, rd_valid, rd_dirty, rd_rank} = rd_word_ff;
      end else begin
         rd_tag   = '0;
         rd_count = '0;
         rd_valid = 1'b0;
         rd_dirty = 1'b0;
         rd_rank  = LAST_RANK - rd_addr_ff;
      end
   end

endmodule

`default_nettype wire

// ----- src/bbc_ctrl.sv -----
`default_nettype none

module bbc_ctrl
   import bbc_pkg::*;
#(
   parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
   parameter int BLOCK_BITS  = BLOCK_BITS_DEF,
   localparam int IB = $clog2(ENTRY_COUNT)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [15:0]           req_block_number,
   input  wire logic [3:0]            req_buffer_index,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [1:0]            rsp_status,
   output logic      [3:0]            rsp_entry_index,
   output logic      [1:0]            rsp_disk_command,
   output logic      [15:0]           rsp_disk_block,
   output logic      [IB-1:0]         rd_addr,
   input  wire logic [BLOCK_BITS-1:0] rd_tag,
   input  wire logic [7:0]            rd_count,
   input  wire logic                  rd_valid,
   input  wire logic                  rd_dirty,
   input  wire logic [IB-1:0]         rd_rank,
   output logic                       wr_en,
   output logic      [IB-1:0]         wr_addr,
   output logic      [BLOCK_BITS-1:0] wr_tag,
   output logic      [7:0]            wr_count,
   output logic                       wr_valid,
   output logic                       wr_dirty,
   output logic      [IB-1:0]         wr_rank
);

   localparam int CB = $clog2(ENTRY_COUNT + 1);
   localparam int XB = (IB > 4) ? IB : 4;
   localparam int WB = (BLOCK_BITS > 16) ? BLOCK_BITS : 16;
   localparam logic [CB-1:0] SCAN_END = CB'(ENTRY_COUNT);

   ctl_state_type state_ff, state_in;

   logic [BLOCK_BITS-1:0] tag_ff, tag_in;
   logic [3:0]            idx_ff, idx_in;
   logic [CB-1:0]         cnt_ff, cnt_in;
   logic                  found_ff, found_in;
   logic                  miss_ff, miss_in;
   logic [IB-1:0]         best_idx_ff, best_idx_in;
   logic [IB-1:0]         best_rank_ff, best_rank_in;
   logic [7:0]            best_count_ff, best_count_in;
   logic                  best_valid_ff, best_valid_in;
   logic                  best_dirty_ff, best_dirty_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic [3:0]            res_idx_ff, res_idx_in;
   logic [1:0]            res_cmd_ff, res_cmd_in;
   logic [15:0]           res_blk_ff, res_blk_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [3:0]            rsp_idx_ff, rsp_idx_in;
   logic [1:0]            rsp_cmd_ff, rsp_cmd_in;
   logic [15:0]           rsp_blk_ff, rsp_blk_in;

   logic [WB-1:0] req_blk_ext, tag_ext, rd_tag_ext;
   logic [XB-1:0] idx_ext, best_ext;
   logic [IB-1:0] eidx, scan_idx, scan_rd;
   logic [CB-1:0] cnt_m1;
   logic          have_data, last, take, idx_bad, out_free;
   logic [15:0]   tag16, rd_tag16;
   logic [3:0]    best_idx4;

   assign req_blk_ext = WB'(req_block_number);
   assign tag_ext     = WB'(tag_ff);
   assign rd_tag_ext  = WB'(rd_tag);
   assign tag16       = tag_ext[15:0];
   assign rd_tag16    = rd_tag_ext[15:0];
   assign idx_ext     = XB'(idx_ff);
   assign eidx        = idx_ext[IB-1:0];
   assign best_ext    = XB'(best_idx_ff);
   assign best_idx4   = best_ext[3:0];
   assign idx_bad     = 32'(req_buffer_index) >= 32'(ENTRY_COUNT);

   // read address runs ahead of the data under test: the read data is registered
   assign cnt_m1    = cnt_ff - CB'(1);
   assign scan_idx  = cnt_m1[IB-1:0];
   assign last      = cnt_ff == SCAN_END;
   assign have_data = cnt_ff != '0;
   assign scan_rd   = last ? '0 : cnt_ff[IB-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_stall        = state_ff != S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_index  = rsp_idx_ff;
   assign rsp_disk_command = rsp_cmd_ff;
   assign rsp_disk_block   = rsp_blk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff        <= tag_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      found_ff      <= found_in;
      miss_ff       <= miss_in;
      best_idx_ff   <= best_idx_in;
      best_rank_ff  <= best_rank_in;
      best_count_ff <= best_count_in;
      best_valid_ff <= best_valid_in;
      best_dirty_ff <= best_dirty_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_cmd_ff    <= res_cmd_in;
      res_blk_ff    <= res_blk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_blk_ff    <= rsp_blk_in;
   end

   always_comb begin
      state_in      = state_ff;
      tag_in        = tag_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      miss_in       = miss_ff;
      best_idx_in   = best_idx_ff;
      best_rank_in  = best_rank_ff;
      best_count_in = best_count_ff;
      best_valid_in = best_valid_ff;
      best_dirty_in = best_dirty_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_cmd_in    = res_cmd_ff;
      res_blk_in    = res_blk_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_blk_in    = rsp_blk_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = eidx;
      wr_tag        = rd_tag;
      wr_count      = rd_count;
      wr_valid      = rd_valid;
      wr_dirty      = rd_dirty;
      wr_rank       = rd_rank;
      take          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               tag_in   = req_blk_ext[BLOCK_BITS-1:0];
               idx_in   = req_buffer_index;
               cnt_in   = '0;
               found_in = 1'b0;
               miss_in  = 1'b0;
               res_status_in = STAT_OK;
               res_idx_in    = '0;
               res_cmd_in    = CMD_NONE;
               res_blk_in    = '0;
               if (req_opcode == OP_ACQUIRE) begin
                  state_in = S_HIT_SCAN;
               end else if (req_opcode == OP_WRITE || req_opcode == OP_RELEASE) begin
                  if (idx_bad) begin
                     res_status_in = STAT_UNHELD;
                     res_idx_in    = req_buffer_index;
                     state_in      = S_PUT;
                  end else if (req_opcode == OP_WRITE) begin
                     state_in = S_WR_RD;
                  end else begin
                     state_in = S_REL_RD;
                  end
               end else begin
                  state_in = S_PUT;
               end
            end
         end

         S_HIT_SCAN, S_FREE_SCAN: begin
            rd_addr = scan_rd;
            if (!last) begin
               cnt_in = cnt_ff + CB'(1);
            end
            // rank compare: lowest rank wins a hit, highest a victim
            if (state_ff == S_HIT_SCAN) begin
               take = have_data && rd_tag == tag_ff &&
                      (!found_ff || rd_rank < best_rank_ff);
            end else begin
               take = have_data && rd_count == '0 && !rd_dirty &&
                      (!found_ff || rd_rank > best_rank_ff);
            end
            if (take) begin
               found_in      = 1'b1;
               best_idx_in   = scan_idx;
               best_rank_in  = rd_rank;
               best_count_in = rd_count;
               best_valid_in = rd_valid;
               best_dirty_in = rd_dirty;
            end
            if (last) begin
               cnt_in = '0;
               if (found_in) begin
                  state_in = S_ACQ_UPD;
               end else if (state_ff == S_HIT_SCAN) begin
                  miss_in  = 1'b1;
                  state_in = S_FREE_SCAN;
               end else begin
                  res_status_in = STAT_NO_FREE;
                  state_in      = S_PUT;
               end
            end
         end

         S_ACQ_UPD: begin
            wr_en    = 1'b1;
            wr_addr  = best_idx_ff;
            wr_tag   = tag_ff;
            wr_valid = 1'b1;
            wr_rank  = best_rank_ff;
            if (miss_ff) begin
               wr_count   = 8'd1;
               wr_dirty   = 1'b0;
               res_cmd_in = CMD_READ;
            end else begin
               wr_count   = (best_count_ff == COUNT_MAX) ? COUNT_MAX
                                                         : best_count_ff + 8'd1;
               wr_dirty   = best_valid_ff && best_dirty_ff;
               res_cmd_in = best_valid_ff ? CMD_NONE : CMD_READ;
            end
            res_status_in = STAT_OK;
            res_idx_in    = best_idx4;
            res_blk_in    = (res_cmd_in == CMD_READ) ? tag16 : '0;
            state_in      = S_PUT;
         end

         S_WR_RD: begin
            rd_addr  = eidx;
            state_in = S_WR_UPD;
         end

         S_WR_UPD: begin
            // transfer completes at once: valid set, dirty cleared
            wr_en         = 1'b1;
            wr_valid      = 1'b1;
            wr_dirty      = 1'b0;
            res_status_in = STAT_OK;
            res_idx_in    = idx_ff;
            res_cmd_in    = CMD_WRITE;
            res_blk_in    = rd_tag16;
            state_in      = S_PUT;
         end

         S_REL_RD: begin
            rd_addr  = eidx;
            state_in = S_REL_CHK;
         end

         S_REL_CHK: begin
            res_idx_in = idx_ff;
            if (rd_count == '0) begin
               res_status_in = STAT_UNHELD;
               state_in      = S_PUT;
            end else if (rd_count != 8'd1) begin
               wr_en    = 1'b1;
               wr_count = rd_count - 8'd1;
               state_in = S_PUT;
            end else begin
               best_rank_in = rd_rank;
               cnt_in       = '0;
               state_in     = S_REL_SWEEP;
            end
         end

         S_REL_SWEEP: begin
            // age every entry more recent than the released one; the released one gets rank 0, count 0
            rd_addr = scan_rd;
            wr_addr = scan_idx;
            if (!last) begin
               cnt_in = cnt_ff + CB'(1);
            end
            if (have_data) begin
               if (scan_idx == eidx) begin
                  wr_en    = 1'b1;
                  wr_count = '0;
                  wr_rank  = '0;
               end else if (rd_rank < best_rank_ff) begin
                  wr_en   = 1'b1;
                  wr_rank = rd_rank + IB'(1);
               end
            end
            if (last) begin
               state_in = S_PUT;
            end
         end

         S_PUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = res_idx_ff;
               rsp_cmd_in    = res_cmd_ff;
               rsp_blk_in    = res_blk_ff;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- src/bbc_check.sv -----
`default_nettype none

module bbc_check
   import bbc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_opcode,
   input wire logic [15:0] req_block_number,
   input wire logic [3:0]  req_buffer_index,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic [3:0]  rsp_entry_index,
   input wire logic [1:0]  rsp_disk_command,
   input wire logic [15:0] rsp_disk_block
);

   // one word in flight: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted back to back");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_entry_index) && $stable(rsp_disk_command) &&
         $stable(rsp_disk_block))
      else $error("stalled response changed");

   a_no_cmd_no_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_disk_command == CMD_NONE |-> rsp_disk_block == 16'd0)
      else $error("disk block without disk command");

   a_error_no_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_disk_command == CMD_NONE)
      else $error("disk command on error status");

   a_no_free_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_NO_FREE |-> rsp_entry_index == 4'd0)
      else $error("entry index on no free entry");

endmodule

bind block_buffer_cache_mru_top bbc_check u_bbc_check (.*);

`default_nettype wire
